[hw/rtl/dufg_pkg.sv]
// dufg_pkg: types, constants and helper functions for the uniform float generator
// used by dufg_step and downey_uniform_float_generator; no dependencies
package dufg_pkg;

    localparam int WORD_W  = 32;
    localparam int EXP_W   = 7;
    localparam int HELD_W  = 24;
    localparam int MANT_W  = 23;
    localparam int FLOAT_W = 30;
    localparam int SUB_W   = 6;

    localparam logic [EXP_W-1:0] START_EXP = 7'd126;
    localparam logic [EXP_W-1:0] BYTE_EXP  = 7'd118;
    localparam logic [SUB_W-1:0] ZERO_SUB  = 6'd32;

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_EXP   = 2'd1;
    localparam logic [1:0] PH_MANT  = 2'd2;
    localparam logic [1:0] PH_BYTE  = 2'd3;

    typedef struct packed {
        logic [1:0]        phase;
        logic [EXP_W-1:0]  exp_acc;
        logic [HELD_W-1:0] held;
    } dufg_state_t;

    typedef struct packed {
        logic               valid;
        logic [FLOAT_W-1:0] bits;
    } dufg_result_t;

    // trailing zero count of a nonzero word, binary search in five steps
    function automatic logic [SUB_W-1:0] trailing_zeros(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        logic [SUB_W-1:0]  n;
        v = w;
        n = '0;
        if (v[15:0] == 16'h0) begin
            n = n + 6'd16;
            v = v >> 16;
        end
        if (v[7:0] == 8'h0) begin
            n = n + 6'd8;
            v = v >> 8;
        end
        if (v[3:0] == 4'h0) begin
            n = n + 6'd4;
            v = v >> 4;
        end
        if (v[1:0] == 2'h0) begin
            n = n + 6'd2;
            v = v >> 2;
        end
        if (v[0] == 1'b0) begin
            n = n + 6'd1;
        end
        return n;
    endfunction

    // exponent field over the mantissa, rounded up on an empty mantissa with the top bit set
    function automatic logic [FLOAT_W-1:0] finish(input logic [HELD_W-1:0] bits24,
                                                   input logic [EXP_W-1:0] e);
        logic [MANT_W-1:0] mant;
        logic [EXP_W-1:0]  e_out;
        mant  = bits24[MANT_W-1:0];
        e_out = e;
        if (mant == '0 && bits24[HELD_W-1]) begin
            e_out = e + 7'd1;
        end
        return {e_out, mant};
    endfunction

endpackage

[hw/rtl/dufg_step.sv]
// dufg_step: combinational next state and result for one accepted random word
// depends on dufg_pkg
module dufg_step import dufg_pkg::*; (
    input  logic [WORD_W-1:0] word,
    input  logic              mode,
    input  dufg_state_t       cur,
    output dufg_state_t       nxt,
    output dufg_result_t      res
);

    logic [SUB_W-1:0] tz;
    logic [SUB_W-1:0] sub;
    logic [EXP_W-1:0] exp_base;
    logic [EXP_W-1:0] exp_take;
    logic             take_done;
    logic             word_zero;

    assign word_zero = (word == '0);
    assign tz        = trailing_zeros(word);
    assign sub       = word_zero ? ZERO_SUB : tz;
    assign exp_base  = (cur.phase == PH_FIRST) ? START_EXP : cur.exp_acc;

    // one exponent word: clamp at zero, a nonzero word ends the exponent part
    always_comb begin
        if ({1'b0, sub} > exp_base) begin
            exp_take  = '0;
            take_done = 1'b1;
        end else begin
            exp_take  = exp_base - {1'b0, sub};
            take_done = !word_zero;
        end
    end

    always_comb begin
        nxt       = cur;
        res.valid = 1'b0;
        res.bits  = '0;
        case (cur.phase)
            PH_FIRST: begin
                if (mode) begin
                    nxt.held = word[WORD_W-1:8];
                    if (word[7:0] != 8'h0) begin
                        res.valid   = 1'b1;
                        res.bits    = finish(word[WORD_W-1:8], START_EXP - {1'b0, tz});
                        nxt.exp_acc = START_EXP;
                    end else begin
                        nxt.exp_acc = BYTE_EXP;
                        nxt.phase   = PH_BYTE;
                    end
                end else begin
                    nxt.exp_acc = exp_take;
                    nxt.phase   = take_done ? PH_MANT : PH_EXP;
                end
            end
            PH_EXP: begin
                nxt.exp_acc = exp_take;
                nxt.phase   = take_done ? PH_MANT : PH_EXP;
            end
            PH_MANT: begin
                res.valid   = 1'b1;
                res.bits    = finish(word[WORD_W-1:8], cur.exp_acc);
                nxt.exp_acc = START_EXP;
                nxt.phase   = PH_FIRST;
            end
            PH_BYTE: begin
                if (take_done) begin
                    res.valid   = 1'b1;
                    res.bits    = finish(cur.held, exp_take);
                    nxt.exp_acc = START_EXP;
                    nxt.phase   = PH_FIRST;
                end else begin
                    nxt.exp_acc = exp_take;
                end
            end
            default: begin
                nxt.phase = PH_FIRST;
            end
        endcase
    end

endmodule

[hw/rtl/downey_uniform_float_generator.sv]
// downey_uniform_float_generator: uniform [0,1] single-precision floats from random words
// a result is registered and appears in the cycle after the request that completes it
// throughput: one random word per cycle while the output is not stalled, set by the combinational step logic
// the output register holds a result until taken; a request is taken alongside
// synchronous active-low reset: mode 0, idle phase, exponent 126, no result pending
module downey_uniform_float_generator import dufg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // [31:0] random_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // [29:0] float_bits, [31:30] zero
);

    logic               mode_reg;
    dufg_state_t        state_reg;
    dufg_state_t        state_next;
    dufg_result_t       step_res;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [FLOAT_W-1:0] out_bits_reg;
    logic               take_in;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign take_in   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(32 - FLOAT_W){1'b0}}, out_bits_reg};

    dufg_step u_step (
        .word (s_tdata),
        .mode (mode_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (take_in && step_res.valid) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            state_reg     <= '{phase: PH_FIRST, exp_acc: START_EXP, held: '0};
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
            if (take_in) begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in && step_res.valid) begin
            out_bits_reg <= step_res.bits;
        end
    end

endmodule

[hw/rtl/dufg_checker.sv]
// dufg_checker: port-level assertions for downey_uniform_float_generator
// depends on nothing but the top level ports; bound to the top level below
module dufg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // nothing pending straight after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // never above one, padding bits clear
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:30] == 2'b00 &&
                     (m_tdata[29:23] != 7'd127 || m_tdata[22:0] == 23'h0))
        else $error("result outside unit interval");

    // an empty output stage always takes a request
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !m_tvalid |-> s_tready)
        else $error("request stalled with nothing pending");

endmodule

bind downey_uniform_float_generator dufg_checker u_dufg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for downey_uniform_float_generator, random words in, floats out
// depends on dufg_pkg and the rtl of the generator; holds its own float predictor
module tb import dufg_pkg::*; ();

    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_WORDS = 250;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // [31:0] random_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [29:0] float_bits, [31:30] zero

    logic [WORD_W-1:0]  word_backlog[$];
    logic [FLOAT_W-1:0] pending_floats[$];
    logic [FLOAT_W-1:0] want_float;
    int unsigned        words_queued = 0;
    int unsigned        words_taken = 0;
    int unsigned        mismatches = 0;
    int unsigned        send_idle_pct = 8;
    int unsigned        recv_idle_pct = 88;
    int unsigned        quiet_cycles = 0;

    // predictor state
    logic               gen_mode = 1'b0;
    logic [1:0]         gen_phase = PH_FIRST;
    logic [EXP_W-1:0]   gen_exp = START_EXP;
    logic [HELD_W-1:0]  gen_held = '0;

    downey_uniform_float_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned low_zero_run(input logic [WORD_W-1:0] w);
        int unsigned n;
        n = 0;
        while (n < WORD_W && !w[n]) n++;
        return n;
    endfunction

    function automatic logic [FLOAT_W-1:0] pack_float(input logic [HELD_W-1:0] top_bits,
                                                      input logic [EXP_W-1:0] e);
        logic [EXP_W-1:0] e_out;
        e_out = e;
        // empty mantissa with the top bit set rounds up
        if (top_bits[MANT_W-1:0] == '0 && top_bits[HELD_W-1]) e_out = e + 7'd1;
        return {e_out, top_bits[MANT_W-1:0]};
    endfunction

    // true once the exponent part is complete
    function automatic logic apply_exp_word(input logic [WORD_W-1:0] w);
        int unsigned sub;
        sub = (w == '0) ? 32 : low_zero_run(w);
        if (sub > gen_exp) begin
            gen_exp = '0;
            return 1'b1;
        end
        gen_exp = gen_exp - sub[EXP_W-1:0];
        return w != '0;
    endfunction

    function automatic void predict_float(input logic [WORD_W-1:0] w);
        logic [1:0] ph;
        logic [EXP_W-1:0] e;
        ph = gen_phase;
        if (ph == PH_FIRST) begin
            gen_exp = START_EXP;
            if (gen_mode) begin
                gen_held = w[31:8];
                if (w[7:0] != 8'h00) begin
                    e = START_EXP - EXP_W'(low_zero_run({24'h0, w[7:0]}));
                    pending_floats.push_back(pack_float(gen_held, e));
                    return;
                end
                gen_exp = BYTE_EXP;
                gen_phase = PH_BYTE;
                return;
            end
            ph = PH_EXP;
        end
        case (ph)
            PH_EXP: begin
                gen_phase = apply_exp_word(w) ? PH_MANT : PH_EXP;
            end
            PH_MANT: begin
                pending_floats.push_back(pack_float(w[31:8], gen_exp));
                gen_phase = PH_FIRST;
                gen_exp = START_EXP;
            end
            default: begin
                if (apply_exp_word(w)) begin
                    pending_floats.push_back(pack_float(gen_held, gen_exp));
                    gen_phase = PH_FIRST;
                    gen_exp = START_EXP;
                end
            end
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_float(s_tdata);
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (word_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= word_backlog.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_floats.size() == 0) begin
                    $error("float_bits: expected none, actual %h", m_tdata);
                    mismatches++;
                end else begin
                    want_float = pending_floats.pop_front();
                    if (m_tdata !== {2'b00, want_float}) begin
                        $error("float_bits: expected %h, actual %h", {2'b00, want_float}, m_tdata);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no request taken anywhere
    initial begin
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic push_word(input logic [WORD_W-1:0] w);
        word_backlog.push_back(w);
        words_queued++;
    endtask

    function automatic logic [WORD_W-1:0] shaped_word();
        logic [WORD_W-1:0] w;
        w = $urandom;
        case ($urandom_range(9))
            5: w = '0;
            6: w = w << $urandom_range(31);
            7: w = {1'b1, 23'h0, w[7:0]};
            8: w = {1'b0, 23'h0, w[7:0]};
            9: w[7:0] = 8'h00;
            default: ;
        endcase
        return w;
    endfunction

    // one well-formed request sequence for the given mode, or a stray word
    task automatic queue_float_request(input logic m);
        logic [WORD_W-1:0] w;
        int unsigned zeros;
        zeros = ($urandom_range(2) == 0) ? $urandom_range(5) : 0;
        if ($urandom_range(9) == 0) begin
            push_word(shaped_word());
        end else if (!m) begin
            repeat (zeros) push_word('0);
            push_word(({$urandom} | 32'h1) << $urandom_range(31));
            push_word(shaped_word());
        end else begin
            w = shaped_word();
            if ($urandom_range(1)) w[7:0] = 8'h00;
            push_word(w);
            if (w[7:0] == 8'h00) begin
                repeat (zeros) push_word('0);
                push_word(({$urandom} | 32'h1) << $urandom_range(31));
            end
        end
    endtask

    // wait until every word is taken and every float has come out
    task automatic settle();
        do @(posedge aclk);
        while (words_taken != words_queued || pending_floats.size() != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        cfg_data  <= m;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_mode = m;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // mode 0: exactly one, clamp after four zero words, exponent run down to zero
        write_mode(1'b0);
        push_word(32'h0000_0001);
        push_word(32'h8000_00FF);
        repeat (4) push_word('0);
        push_word(32'h1234_5678);
        push_word(32'h8000_0000);
        push_word(32'h8000_0000);
        push_word('0);
        push_word('0);
        push_word(32'h0000_0002);
        push_word(32'h0000_0000);
        settle();

        // mode 1: low byte used directly, round up, clamp after the byte, item left open
        write_mode(1'b1);
        push_word(32'h0000_00FF);
        push_word(32'h8000_0080);
        push_word(32'h8000_0000);
        repeat (4) push_word('0);
        push_word('0);
        settle();

        // open mode 1 item finishes under mode 0, then a mode 0 item left open
        write_mode(1'b0);
        push_word(32'h0000_0004);
        push_word('0);
        settle();

        write_mode(1'b1);
        push_word(32'h0000_0010);
        push_word(32'hABCD_EF12);

        for (int prof = 0; prof < 3; prof++) begin
            for (int m = 0; m < 2; m++) begin
                settle();
                send_idle_pct = (prof == 0) ? 8 : (prof == 1) ? 88 : 0;
                recv_idle_pct = (prof == 0) ? 88 : (prof == 1) ? 8 : 0;
                write_mode(m[0]);
                while (word_backlog.size() < PHASE_WORDS) queue_float_request(m[0]);
            end
        end

        settle();
        repeat (5) @(posedge aclk);
        if (mismatches == 0 && pending_floats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/dufg_pkg.sv
hw/rtl/dufg_step.sv
hw/rtl/downey_uniform_float_generator.sv
hw/rtl/dufg_checker.sv
tb/tb.sv
